// ===== hdl/delimited_chunk_range_finder_assert.svh =====
// Assertion macros shared by the chunk range finder RTL.
`ifndef DELIMITED_CHUNK_RANGE_FINDER_ASSERT_SVH
`define DELIMITED_CHUNK_RANGE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DCRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dcrf assertion failed");

// Next-cycle implication, disabled during reset.
`define DCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dcrf assertion failed");

`endif

// ===== hdl/dcrf_pkg.sv =====
// Types and constants of the delimited chunk range finder.
package dcrf_pkg;

    localparam int FIELD_W = 17;

    // Chunking modes
    localparam logic [1:0] MODE_CHAR = 2'd0;
    localparam logic [1:0] MODE_ITEM = 2'd1;
    localparam logic [1:0] MODE_LINE = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_CHUNK_MODE     = 2'd0;
    localparam logic [1:0] REG_ITEM_DELIMITER = 2'd1;
    localparam logic [1:0] REG_RANGE_START    = 2'd2;
    localparam logic [1:0] REG_RANGE_END      = 2'd3;

    // Input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    // Token kinds passed from front to back
    localparam logic [1:0] TOK_PLAIN = 2'd0;
    localparam logic [1:0] TOK_DELIM = 2'd1;
    localparam logic [1:0] TOK_END   = 2'd2;

    typedef logic [1:0] token_t;

    typedef struct packed {
        logic [1:0]         chunk_mode;
        logic [7:0]         item_delimiter;
        logic [FIELD_W-1:0] range_start;
        logic [FIELD_W-1:0] range_end;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] chunk_start;
        logic [FIELD_W-1:0] chunk_end;
        logic [FIELD_W-1:0] delete_start;
        logic [FIELD_W-1:0] delete_end;
    } result_t;

endpackage

// ===== hdl/dcrf_fifo.sv =====
// Small register FIFO used for the token and result queues.
`include "delimited_chunk_range_finder_assert.svh"

module dcrf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `DCRF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DCRF_ASSERT_NEXT(a_push_fills, clk, rst_n, do_push && !do_pop, !empty)
    `DCRF_ASSERT_NEXT(a_pop_drains, clk, rst_n, do_pop && !do_push, !full)

endmodule

// ===== hdl/dcrf_front.sv =====
// Front end: takes input characters and classifies them into tokens.
module dcrf_front (
    input  dcrf_pkg::cfg_t     cfg,
    input  logic               push,
    output logic               full,
    input  dcrf_pkg::in_item_t char_item,
    output logic               tok_push,
    output dcrf_pkg::token_t   tok_kind,
    input  logic               tok_full
);

    import dcrf_pkg::*;

    logic scanning;
    logic is_delim;

    assign scanning = (cfg.chunk_mode == MODE_ITEM) || (cfg.chunk_mode == MODE_LINE);

    always_comb
    begin
        if (cfg.chunk_mode == MODE_ITEM)
        begin
            is_delim = (char_item.char_value == cfg.item_delimiter);
        end
        else
        begin
            is_delim = (char_item.char_value == CH_LF) || (char_item.char_value == CH_CR);
        end
    end

    always_comb
    begin
        if (char_item.op == OP_END)
        begin
            tok_kind = TOK_END;
        end
        else if (is_delim)
        begin
            tok_kind = TOK_DELIM;
        end
        else
        begin
            tok_kind = TOK_PLAIN;
        end
    end

    // characters outside the scanning modes have no effect; drop them here
    assign full     = tok_full;
    assign tok_push = push && !tok_full && ((char_item.op == OP_END) || scanning);

endmodule

// ===== hdl/dcrf_back.sv =====
// Back end: scan state, range capture and result generation.
`include "delimited_chunk_range_finder_assert.svh"

module dcrf_back #(
    parameter int MAX_LEN = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dcrf_pkg::cfg_t    cfg,
    input  logic              tok_empty,
    input  dcrf_pkg::token_t  tok_kind,
    output logic              tok_pop,
    input  logic              res_full,
    output logic              res_push,
    output dcrf_pkg::result_t res_data
);

    import dcrf_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam int EXT_W = (POS_W > FIELD_W) ? POS_W : FIELD_W;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] cur_start_reg, cur_start_next;
    logic [POS_W-1:0] cur_del_reg, cur_del_next;
    logic [POS_W-1:0] cap_start_reg, cap_start_next;
    logic [POS_W-1:0] cap_del_reg, cap_del_next;
    logic             given_reg, given_next;

    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] eff_start;
    logic [POS_W-1:0] eff_del;
    logic             at_start;
    logic             at_end;
    logic             active;

    function automatic logic [FIELD_W-1:0] to_field(input logic [POS_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[FIELD_W-1:0];
    endfunction

    assign tok_pop   = !tok_empty && !res_full;
    assign pos_inc   = POS_W'(pos_reg + 1'b1);
    assign at_start  = (EXT_W'(count_reg) == EXT_W'(cfg.range_start));
    assign at_end    = (EXT_W'(count_reg) == EXT_W'(cfg.range_end));
    assign active    = !given_reg && (pos_reg < POS_W'(MAX_LEN));
    // start capture takes effect in the same step that may report it
    assign eff_start = at_start ? cur_start_reg : cap_start_reg;
    assign eff_del   = at_start ? cur_del_reg : cap_del_reg;

    always_comb
    begin
        pos_next       = pos_reg;
        count_next     = count_reg;
        cur_start_next = cur_start_reg;
        cur_del_next   = cur_del_reg;
        cap_start_next = cap_start_reg;
        cap_del_next   = cap_del_reg;
        given_next     = given_reg;
        res_push       = 1'b0;
        res_data       = '0;
        if (tok_pop)
        begin
            case (tok_kind)
                TOK_END:
                begin
                    if (!given_reg)
                    begin
                        res_push = 1'b1;
                        case (cfg.chunk_mode) inside
                            MODE_CHAR:
                            begin
                                res_data.chunk_start  = cfg.range_start;
                                res_data.chunk_end    = cfg.range_end;
                                res_data.delete_start = cfg.range_start;
                                res_data.delete_end   = cfg.range_end;
                            end
                            MODE_ITEM, MODE_LINE:
                            begin
                                res_data.chunk_start  = to_field(eff_start);
                                res_data.delete_start = to_field(eff_del);
                                res_data.chunk_end    = at_end ? to_field(pos_reg) : '0;
                                res_data.delete_end   = at_end ? to_field(pos_reg) : '0;
                            end
                            default:
                            begin
                                res_data = '0;
                            end
                        endcase
                    end
                    pos_next       = '0;
                    count_next     = '0;
                    cur_start_next = '0;
                    cur_del_next   = '0;
                    cap_start_next = '0;
                    cap_del_next   = '0;
                    given_next     = 1'b0;
                end
                TOK_PLAIN:
                begin
                    if (active)
                    begin
                        pos_next = pos_inc;
                    end
                end
                TOK_DELIM:
                begin
                    if (active)
                    begin
                        cap_start_next = eff_start;
                        cap_del_next   = eff_del;
                        cur_del_next   = pos_reg;
                        cur_start_next = pos_inc;
                        pos_next       = pos_inc;
                        if (at_end)
                        begin
                            res_push              = 1'b1;
                            res_data.chunk_start  = to_field(eff_start);
                            res_data.chunk_end    = to_field(pos_reg);
                            res_data.delete_start = to_field(eff_del);
                            res_data.delete_end   = (cfg.range_start == '0) ?
                                                    to_field(pos_inc) : to_field(pos_reg);
                            given_next            = 1'b1;
                        end
                        else
                        begin
                            count_next = POS_W'(count_reg + 1'b1);
                        end
                    end
                end
                default:
                begin
                    pos_next = pos_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            cur_start_reg <= '0;
            cur_del_reg   <= '0;
            cap_start_reg <= '0;
            cap_del_reg   <= '0;
            given_reg     <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            cur_start_reg <= cur_start_next;
            cur_del_reg   <= cur_del_next;
            cap_start_reg <= cap_start_next;
            cap_del_reg   <= cap_del_next;
            given_reg     <= given_next;
        end
    end

    `DCRF_ASSERT_NOW(a_result_needs_token, clk, rst_n, res_push, tok_pop && !res_full)
    `DCRF_ASSERT_NOW(a_one_result, clk, rst_n, given_reg, !res_push)
    `DCRF_ASSERT_NEXT(a_end_clears, clk, rst_n, tok_pop && (tok_kind == TOK_END),
                      (pos_reg == '0) && (count_reg == '0) && !given_reg)
    `DCRF_ASSERT_NOW(a_count_le_pos, clk, rst_n, 1'b1, count_reg <= pos_reg)

endmodule

// ===== hdl/delimited_chunk_range_finder.sv =====
// Top level of the delimited chunk range finder.
// Feed a string one character per push (op = 0), closed by an end marker
// (op = 1); chunks are counted from 0, split on the item delimiter (item mode)
// or on CR/LF (line mode). For each string at most one result comes out of the
// result queue: the byte offsets of chunks range_start..range_end plus the wider
// delete range, given at the delimiter that closes chunk range_end or at the end
// marker. Character mode returns the configured indices at the end marker.
// The block accepts one character per cycle while the token queue is not full;
// with both queues drained, a result reaches the result ports once its token
// has been registered in the token queue and the back end has then written
// the result queue. Throughput is set by the back end, which applies one token
// per cycle to its scan counters and offset registers while the result queue
// is not full. A front end classifies each character into a token,
// a two-entry token queue decouples it from the back end, and a two-entry
// result queue lets the back end keep running while a result waits to be
// popped. Configuration is written through cfg_write/cfg_index/cfg_data and
// must only change while no transfer is in flight. Characters past MAX_LEN in
// one string are ignored.
module delimited_chunk_range_finder #(
    parameter int MAX_LEN = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [dcrf_pkg::FIELD_W-1:0]        cfg_data,
    input  logic                                push,
    output logic                                full,
    input  dcrf_pkg::in_item_t                  char_item,
    output logic                                empty,
    input  logic                                pop,
    output dcrf_pkg::result_t                   result
);

    import dcrf_pkg::*;

    localparam int TOK_W = $bits(token_t);
    localparam int RES_W = $bits(result_t);

    cfg_t              cfg_reg, cfg_next;

    logic              tok_push;
    logic              tok_full;
    token_t            tok_kind_in;
    logic [TOK_W-1:0]  tok_rdata;
    token_t            tok_kind_out;
    logic              tok_empty;
    logic              tok_pop;

    logic              res_push;
    logic              res_full;
    result_t           res_data;
    logic [RES_W-1:0]  res_rdata;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CHUNK_MODE:     cfg_next.chunk_mode     = cfg_data[1:0];
                REG_ITEM_DELIMITER: cfg_next.item_delimiter = cfg_data[7:0];
                REG_RANGE_START:    cfg_next.range_start    = cfg_data;
                REG_RANGE_END:      cfg_next.range_end      = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chunk_mode     <= MODE_ITEM;
            cfg_reg.item_delimiter <= 8'd44;
            cfg_reg.range_start    <= '0;
            cfg_reg.range_end      <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify characters into tokens
    dcrf_front u_front (
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .char_item (char_item),
        .tok_push  (tok_push),
        .tok_kind  (tok_kind_in),
        .tok_full  (tok_full)
    );

    // Token queue between front and back
    dcrf_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (2)
    ) u_tok_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tok_push),
        .full  (tok_full),
        .wdata (tok_kind_in),
        .pop   (tok_pop),
        .empty (tok_empty),
        .rdata (tok_rdata)
    );

    assign tok_kind_out = tok_rdata;

    // Back end: scan state and result generation
    dcrf_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_empty (tok_empty),
        .tok_kind  (tok_kind_out),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // Result queue toward the consumer
    dcrf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_data),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rdata)
    );

    assign result = res_rdata;

endmodule
